// File: sv/crclrm_pkg.sv
// Shared types, codes and CRC helper for the CRC-32 link receive monitor.
`timescale 1ns / 1ps

package crclrm_pkg;

	localparam int MAX_PACKET_DEF = 1024;
	localparam logic [23:0] IDLE_MAX = 24'hFFFFFF;
	localparam logic [23:0] TIMEOUT_RESET = 24'd1000;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;

	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_TICK    = 2'd1,
		KIND_LISTEN  = 2'd2,
		KIND_CONNECT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ROLE_NONE   = 2'd0,
		ROLE_SERVER = 2'd1,
		ROLE_CLIENT = 2'd2
	} role_t;

	typedef enum logic [2:0] {
		ST_DISC       = 3'd0,
		ST_LISTEN     = 3'd1,
		ST_CONNECTING = 3'd2,
		ST_CONNECTED  = 3'd3,
		ST_FAILED     = 3'd4
	} link_state_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        payload_valid;
		logic        packet_end;
		logic        packet_ok;
		link_state_t link_status;
		logic        connect_event;
		logic        disconnect_event;
	} res_t;

	// reflected CRC-32 update over one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

// File: sv/crc32_link_receive_monitor.sv
// Top level of the CRC-32 link receive monitor: packet check, link state and APB registers.
`timescale 1ns / 1ps

// One request is taken per clock while in_ready is high. Each request updates
// the packet checker (byte-wide CRC-32 step, header capture, byte count) and
// the link state machine and writes one result into a two-entry output
// buffer, so requests keep flowing at one per cycle while out_ready is high
// and in_ready drops only when both buffer entries hold results. The
// datagram's first four bytes are its big-endian CRC; the check hashes the
// 32-bit salt register in their place, then the payload. Bytes beyond
// MAX_PACKET are dropped from hashing and output. Registers: 0x0 salt, 0x4
// timeout_ticks (24 bits); write only while the block is idle.
module crc32_link_receive_monitor #(
	parameter int MAX_PACKET = crclrm_pkg::MAX_PACKET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	input  logic [31:0] remote_ip,
	input  logic [15:0] remote_port,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  payload_byte,
	output logic        payload_valid,
	output logic        packet_end,
	output logic        packet_ok,
	output logic [2:0]  link_status,
	output logic        connect_event,
	output logic        disconnect_event
);

	localparam int CW = $clog2(MAX_PACKET + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PACKET);
	localparam logic [CW-1:0] HDR_LEN = CW'(4);

	logic [31:0] salt_q;
	logic [23:0] timeout_ticks_q;
	crclrm_pkg::role_t role_q, role_d;
	crclrm_pkg::link_state_t state_q, state_d;
	logic [31:0] peer_ip_q, peer_ip_d;
	logic [15:0] peer_port_q, peer_port_d;
	logic [23:0] idle_q, idle_d, idle_inc;
	logic [31:0] crc_q, crc_d, crc_w, crc_n;
	logic [31:0] hdr_q, hdr_d, hdr_w, hdr_n;
	logic [CW-1:0] cnt_q, cnt_d, cnt_w, cnt_n;
	logic [7:0] salt_byte;
	logic crc_good, peer_match, adopt;
	logic acc;
	crclrm_pkg::res_t res, out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	// configuration port
	assign pready = 1'b1;
	assign prdata = paddr[2] ? {8'd0, timeout_ticks_q} : salt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			salt_q <= '0;
			timeout_ticks_q <= crclrm_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2]) begin
				timeout_ticks_q <= pwdata[23:0];
			end else begin
				salt_q <= pwdata;
			end
		end
	end

	assign in_ready = !skid_valid_q;
	assign acc = in_valid && in_ready;

	always_comb begin
		case (cnt_w[1:0])
			2'd0: salt_byte = salt_q[31:24];
			2'd1: salt_byte = salt_q[23:16];
			2'd2: salt_byte = salt_q[15:8];
			default: salt_byte = salt_q[7:0];
		endcase
	end

	assign idle_inc = (idle_q == crclrm_pkg::IDLE_MAX) ? idle_q : idle_q + 24'd1;

	always_comb begin
		role_d = role_q;
		state_d = state_q;
		peer_ip_d = peer_ip_q;
		peer_port_d = peer_port_q;
		idle_d = idle_q;
		crc_d = crc_q;
		hdr_d = hdr_q;
		cnt_d = cnt_q;
		res = '0;
		res.link_status = state_q;
		cnt_w = first_byte ? '0 : cnt_q;
		crc_w = first_byte ? 32'hFFFFFFFF : crc_q;
		hdr_w = first_byte ? 32'd0 : hdr_q;
		crc_n = crc_w;
		hdr_n = hdr_w;
		cnt_n = cnt_w;
		crc_good = 1'b0;
		adopt = 1'b0;
		peer_match = 1'b0;
		case (crclrm_pkg::kind_t'(kind))
			crclrm_pkg::KIND_BYTE: begin
				if (cnt_w < CNT_MAX) begin
					if (cnt_w < HDR_LEN) begin
						hdr_n = {hdr_w[23:0], data_byte};
						crc_n = crclrm_pkg::crc_byte(crc_w, salt_byte);
					end else begin
						crc_n = crclrm_pkg::crc_byte(crc_w, data_byte);
						res.payload_byte = data_byte;
						res.payload_valid = 1'b1;
					end
					cnt_n = cnt_w + CW'(1);
				end
				crc_d = crc_n;
				hdr_d = hdr_n;
				cnt_d = cnt_n;
				if (last_byte) begin
					res.packet_end = 1'b1;
					crc_good = (cnt_n > HDR_LEN) && ((~crc_n) == hdr_n);
					if (crc_good) begin
						adopt = (role_q == crclrm_pkg::ROLE_SERVER)
							&& (state_q != crclrm_pkg::ST_CONNECTED);
						peer_match = adopt
							|| ((remote_ip == peer_ip_q) && (remote_port == peer_port_q));
						if (adopt) begin
							state_d = crclrm_pkg::ST_CONNECTED;
							peer_ip_d = remote_ip;
							peer_port_d = remote_port;
							res.connect_event = 1'b1;
						end
						if (peer_match) begin
							if ((role_q == crclrm_pkg::ROLE_CLIENT)
								&& (state_q == crclrm_pkg::ST_CONNECTING)) begin
								state_d = crclrm_pkg::ST_CONNECTED;
								res.connect_event = 1'b1;
							end
							idle_d = '0;
							res.packet_ok = 1'b1;
						end
					end
					crc_d = 32'hFFFFFFFF;
					hdr_d = '0;
					cnt_d = '0;
				end
			end
			crclrm_pkg::KIND_TICK: begin
				idle_d = idle_inc;
				if (idle_inc > timeout_ticks_q) begin
					if (state_q == crclrm_pkg::ST_CONNECTING
						|| state_q == crclrm_pkg::ST_CONNECTED) begin
						state_d = (state_q == crclrm_pkg::ST_CONNECTING)
							? crclrm_pkg::ST_FAILED : crclrm_pkg::ST_DISC;
						peer_ip_d = '0;
						peer_port_d = '0;
						idle_d = '0;
						res.disconnect_event = 1'b1;
					end
				end
			end
			crclrm_pkg::KIND_LISTEN: begin
				res.disconnect_event = (state_q == crclrm_pkg::ST_CONNECTED);
				idle_d = '0;
				peer_ip_d = '0;
				peer_port_d = '0;
				role_d = crclrm_pkg::ROLE_SERVER;
				state_d = crclrm_pkg::ST_LISTEN;
			end
			default: begin
				res.disconnect_event = (state_q == crclrm_pkg::ST_CONNECTED);
				idle_d = '0;
				peer_ip_d = remote_ip;
				peer_port_d = remote_port;
				role_d = crclrm_pkg::ROLE_CLIENT;
				state_d = crclrm_pkg::ST_CONNECTING;
			end
		endcase
		res.link_status = state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q <= crclrm_pkg::ROLE_NONE;
			state_q <= crclrm_pkg::ST_DISC;
			peer_ip_q <= '0;
			peer_port_q <= '0;
			idle_q <= '0;
			crc_q <= 32'hFFFFFFFF;
			hdr_q <= '0;
			cnt_q <= '0;
		end else if (acc) begin
			role_q <= role_d;
			state_q <= state_d;
			peer_ip_q <= peer_ip_d;
			peer_port_q <= peer_port_d;
			idle_q <= idle_d;
			crc_q <= crc_d;
			hdr_q <= hdr_d;
			cnt_q <= cnt_d;
		end
	end

	// two-entry output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= acc;
			end
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end
		if (acc && out_valid_q && !out_ready) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign payload_byte = out_q.payload_byte;
	assign payload_valid = out_q.payload_valid;
	assign packet_end = out_q.packet_end;
	assign packet_ok = out_q.packet_ok;
	assign link_status = out_q.link_status;
	assign connect_event = out_q.connect_event;
	assign disconnect_event = out_q.disconnect_event;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without output entry");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("byte count beyond MAX_PACKET");

	a_peer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != crclrm_pkg::ST_CONNECTING && state_q != crclrm_pkg::ST_CONNECTED)
		|-> (peer_ip_q == '0 && peer_port_q == '0))
		else $error("peer set while link is not active");

	a_connect_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.connect_event)
		|-> (out_q.link_status == crclrm_pkg::ST_CONNECTED))
		else $error("connect event without connected status");

	a_role_none_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(role_q == crclrm_pkg::ROLE_NONE) |-> (state_q == crclrm_pkg::ST_DISC))
		else $error("link active with no role");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the CRC-32 link receive monitor: queued driver, scoreboard, APB setup.
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_BYTES = crclrm_pkg::MAX_PACKET_DEF;
	localparam logic [2:0] REG_SALT = 3'd0;
	localparam logic [2:0] REG_TIMEOUT = 3'd4;
	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_PRINTED = 30;

	typedef enum {DG_GOOD, DG_CORRUPT, DG_UNMARKED} dg_kind_t;

	typedef struct {
		crclrm_pkg::kind_t kind;
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [31:0] ip;
		logic [15:0] port;
	} req_t;

	typedef logic [7:0] bytes_t[$];

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  kind = crclrm_pkg::KIND_BYTE;
	logic [7:0]  data_byte = '0;
	logic        first_byte = 1'b0;
	logic        last_byte = 1'b0;
	logic [31:0] remote_ip = '0;
	logic [15:0] remote_port = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  payload_byte;
	logic        payload_valid;
	logic        packet_end;
	logic        packet_ok;
	logic [2:0]  link_status;
	logic        connect_event;
	logic        disconnect_event;

	crc32_link_receive_monitor dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .data_byte(data_byte), .first_byte(first_byte),
		.last_byte(last_byte), .remote_ip(remote_ip), .remote_port(remote_port),
		.out_valid(out_valid), .out_ready(out_ready),
		.payload_byte(payload_byte), .payload_valid(payload_valid),
		.packet_end(packet_end), .packet_ok(packet_ok), .link_status(link_status),
		.connect_event(connect_event), .disconnect_event(disconnect_event)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// configuration copy and link/checker state
	logic [31:0] cfg_proto = '0;
	logic [23:0] cfg_timeout = crclrm_pkg::TIMEOUT_RESET;
	crclrm_pkg::role_t       m_role = crclrm_pkg::ROLE_NONE;
	crclrm_pkg::link_state_t m_link = crclrm_pkg::ST_DISC;
	logic [31:0] m_peer_ip = '0;
	logic [15:0] m_peer_port = '0;
	logic [23:0] m_idle = '0;
	logic [31:0] m_crc = '1;
	logic [31:0] m_hdr = '0;
	int          m_count = 0;

	req_t   rx_requests[$];
	crclrm_pkg::res_t link_results[$];
	req_t   drv_req;
	crclrm_pkg::res_t want;
	logic   drv_busy = 1'b0;
	int     drv_wait = 0;
	int     mon_wait = 0;
	int     rx_hold_cycles = 0;
	logic   tx_idle = 1'b1;
	logic   rx_idle = 1'b1;
	int     quiet_cycles = 0;
	int     err_count = 0;
	int     gen_count = 0;
	int     n_reqs = 0;
	int     n_results = 0;
	int     n_ends = 0;
	int     n_ok = 0;
	int     n_conn = 0;
	int     n_drop = 0;
	logic [31:0] pool_ip[4];
	logic [15:0] pool_port[4];

	function automatic logic [31:0] crc_update(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] c;
		c = acc;
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ ({32{c[0] ^ b[i]}} & crclrm_pkg::CRC_POLY);
		end
		return c;
	endfunction

	function automatic void drop_link();
		m_link = crclrm_pkg::ST_DISC;
		m_peer_ip = '0;
		m_peer_port = '0;
		m_idle = '0;
	endfunction

	function automatic crclrm_pkg::res_t next_link_result(input req_t r);
		crclrm_pkg::res_t o;
		o = '0;
		case (r.kind)
			crclrm_pkg::KIND_BYTE: begin
				if (r.first) begin
					m_count = 0;
					m_crc = '1;
					m_hdr = '0;
				end
				if (m_count < MAX_BYTES) begin
					if (m_count < 4) begin
						m_hdr = {m_hdr[23:0], r.data};
						m_crc = crc_update(m_crc, cfg_proto[31 - 8 * m_count -: 8]);
					end else begin
						m_crc = crc_update(m_crc, r.data);
						o.payload_byte = r.data;
						o.payload_valid = 1'b1;
					end
					m_count++;
				end
				if (r.last) begin
					o.packet_end = 1'b1;
					if (m_count > 4 && ~m_crc == m_hdr) begin
						if (m_role == crclrm_pkg::ROLE_SERVER
							&& m_link != crclrm_pkg::ST_CONNECTED) begin
							m_link = crclrm_pkg::ST_CONNECTED;
							m_peer_ip = r.ip;
							m_peer_port = r.port;
							o.connect_event = 1'b1;
						end
						if (r.ip == m_peer_ip && r.port == m_peer_port) begin
							if (m_role == crclrm_pkg::ROLE_CLIENT
								&& m_link == crclrm_pkg::ST_CONNECTING) begin
								m_link = crclrm_pkg::ST_CONNECTED;
								o.connect_event = 1'b1;
							end
							m_idle = '0;
							o.packet_ok = 1'b1;
						end
					end
					m_count = 0;
					m_crc = '1;
					m_hdr = '0;
				end
			end
			crclrm_pkg::KIND_TICK: begin
				if (m_idle != crclrm_pkg::IDLE_MAX) m_idle = m_idle + 24'd1;
				if (m_idle > cfg_timeout) begin
					if (m_link == crclrm_pkg::ST_CONNECTING) begin
						drop_link();
						m_link = crclrm_pkg::ST_FAILED;
						o.disconnect_event = 1'b1;
					end else if (m_link == crclrm_pkg::ST_CONNECTED) begin
						drop_link();
						o.disconnect_event = 1'b1;
					end
				end
			end
			default: begin
				if (m_link == crclrm_pkg::ST_CONNECTED) o.disconnect_event = 1'b1;
				drop_link();
				if (r.kind == crclrm_pkg::KIND_LISTEN) begin
					m_role = crclrm_pkg::ROLE_SERVER;
					m_link = crclrm_pkg::ST_LISTEN;
				end else begin
					m_role = crclrm_pkg::ROLE_CLIENT;
					m_link = crclrm_pkg::ST_CONNECTING;
					m_peer_ip = r.ip;
					m_peer_port = r.port;
				end
			end
		endcase
		o.link_status = m_link;
		n_ends += int'(o.packet_end);
		n_ok += int'(o.packet_ok);
		n_conn += int'(o.connect_event);
		n_drop += int'(o.disconnect_event);
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (err_count < MAX_PRINTED)
			$display("[%0t] MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
				$realtime, n_results, what, got, exp_val);
		err_count++;
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				link_results.push_back(next_link_result(drv_req));
				n_reqs++;
				drv_busy = 1'b0;
				drv_wait = tx_idle ? $urandom_range(0, 17) : 0;
			end
			if (!drv_busy) begin
				if (drv_wait > 0) begin
					drv_wait--;
				end else if (rx_requests.size() != 0) begin
					drv_req = rx_requests.pop_front();
					drv_busy = 1'b1;
					kind <= drv_req.kind;
					data_byte <= drv_req.data;
					first_byte <= drv_req.first;
					last_byte <= drv_req.last;
					remote_ip <= drv_req.ip;
					remote_port <= drv_req.port;
				end
			end
			in_valid <= drv_busy;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (link_results.size() == 0) begin
					report_mismatch("unexpected result", {24'd0, payload_byte}, '0);
				end else begin
					want = link_results.pop_front();
					if (payload_byte !== want.payload_byte)
						report_mismatch("payload_byte", 32'(payload_byte),
							32'(want.payload_byte));
					if (payload_valid !== want.payload_valid)
						report_mismatch("payload_valid", 32'(payload_valid),
							32'(want.payload_valid));
					if (packet_end !== want.packet_end)
						report_mismatch("packet_end", 32'(packet_end), 32'(want.packet_end));
					if (packet_ok !== want.packet_ok)
						report_mismatch("packet_ok", 32'(packet_ok), 32'(want.packet_ok));
					if (link_status !== want.link_status)
						report_mismatch("link_status", 32'(link_status),
							32'(want.link_status));
					if (connect_event !== want.connect_event)
						report_mismatch("connect_event", 32'(connect_event),
							32'(want.connect_event));
					if (disconnect_event !== want.disconnect_event)
						report_mismatch("disconnect_event", 32'(disconnect_event),
							32'(want.disconnect_event));
				end
				n_results++;
				mon_wait = rx_idle ? $urandom_range(0, 17) : 0;
			end
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles--;
				out_ready <= 1'b0;
			end else if (mon_wait > 0) begin
				mon_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic reg_check(input logic [2:0] addr, input logic [31:0] exp_val,
			input logic [31:0] mask);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) !== (exp_val & mask))
			report_mismatch("register readback", prdata, exp_val);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_SALT) begin
			cfg_proto = val;
			reg_check(addr, val, 32'hFFFFFFFF);
		end else if (addr == REG_TIMEOUT) begin
			cfg_timeout = val[23:0];
			reg_check(addr, val, 32'h00FFFFFF);
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (rx_requests.size() != 0 || drv_busy || link_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic add_req(input crclrm_pkg::kind_t k, input logic [7:0] d, input logic f,
			input logic l, input logic [31:0] ip, input logic [15:0] port);
		req_t r;
		r.kind = k;
		r.data = d;
		r.first = f;
		r.last = l;
		r.ip = ip;
		r.port = port;
		rx_requests.push_back(r);
		gen_count++;
	endtask

	// link command or tick with junk in the unused fields
	task automatic add_ctrl(input crclrm_pkg::kind_t k, input logic [31:0] ip,
			input logic [15:0] port);
		add_req(k, 8'($urandom), 1'($urandom), 1'($urandom), ip, port);
	endtask

	function automatic bytes_t rand_body(input int n);
		bytes_t q;
		for (int i = 0; i < n; i++) q.push_back(8'($urandom));
		return q;
	endfunction

	task automatic add_datagram(input bytes_t body, input dg_kind_t how,
			input logic [31:0] ip, input logic [15:0] port);
		logic [31:0] c;
		logic [31:0] sum;
		int plen;
		plen = body.size();
		c = '1;
		for (int i = 0; i < 4; i++) c = crc_update(c, cfg_proto[31 - 8 * i -: 8]);
		for (int i = 0; i < plen && i < MAX_BYTES - 4; i++) c = crc_update(c, body[i]);
		sum = ~c;
		if (how == DG_CORRUPT) sum[$urandom_range(0, 31)] ^= 1'b1;
		for (int i = 0; i < 4 + plen; i++)
			add_req(crclrm_pkg::KIND_BYTE, (i < 4) ? sum[31 - 8 * i -: 8] : body[i - 4],
				i == 0 && how != DG_UNMARKED, i == 3 + plen, ip, port);
	endtask

	task automatic add_short(input int len, input logic [31:0] ip, input logic [15:0] port);
		for (int i = 0; i < len; i++)
			add_req(crclrm_pkg::KIND_BYTE, 8'($urandom), i == 0, i == len - 1, ip, port);
	endtask

	task automatic pick_peer(output logic [31:0] ip, output logic [15:0] port);
		int k;
		if ($urandom_range(0, 99) < 85) begin
			k = $urandom_range(0, 3);
			ip = pool_ip[k];
			port = pool_port[k];
		end else begin
			ip = $urandom;
			port = 16'($urandom);
		end
	endtask

	task automatic random_traffic(input int n);
		int target;
		int pick;
		int plen;
		logic [31:0] ip;
		logic [15:0] port;
		target = gen_count + n;
		while (gen_count < target) begin
			pick = $urandom_range(0, 99);
			pick_peer(ip, port);
			plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
			if (pick < 50) add_datagram(rand_body(plen), DG_GOOD, ip, port);
			else if (pick < 58) add_datagram(rand_body(plen), DG_CORRUPT, ip, port);
			else if (pick < 62) add_short($urandom_range(1, 4), ip, port);
			else if (pick < 66) add_datagram(rand_body(plen), DG_UNMARKED, ip, port);
			else if (pick < 80) repeat ($urandom_range(1, 6))
				add_ctrl(crclrm_pkg::KIND_TICK, $urandom, 16'($urandom));
			else if (pick < 85) add_ctrl(crclrm_pkg::KIND_LISTEN, $urandom, 16'($urandom));
			else if (pick < 91) add_ctrl(crclrm_pkg::KIND_CONNECT, ip, port);
			else repeat ($urandom_range(1, 3))
				add_req(crclrm_pkg::KIND_BYTE, 8'($urandom), 1'($urandom), 1'($urandom),
					$urandom, 16'($urandom));
		end
	endtask

	initial begin
		bytes_t pl;
		pool_ip[0] = '0;
		pool_port[0] = '0;
		pool_ip[1] = '1;
		pool_port[1] = '1;
		pool_ip[2] = $urandom;
		pool_port[2] = 16'($urandom);
		pool_ip[3] = $urandom;
		pool_port[3] = 16'($urandom);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		reg_check(REG_SALT, '0, 32'hFFFFFFFF);
		reg_check(REG_TIMEOUT, {8'd0, crclrm_pkg::TIMEOUT_RESET}, 32'h00FFFFFF);

		// directed: no role yet, so a good packet from 0:0 passes
		pl = {8'h00, 8'hFF};
		add_datagram(pl, DG_GOOD, pool_ip[0], pool_port[0]);
		add_short(4, pool_ip[1], pool_port[1]);
		add_ctrl(crclrm_pkg::KIND_LISTEN, '0, '0);
		pl = {8'h5A};
		add_datagram(pl, DG_GOOD, pool_ip[1], pool_port[1]);
		add_ctrl(crclrm_pkg::KIND_TICK, '1, '1);
		add_ctrl(crclrm_pkg::KIND_CONNECT, pool_ip[2], pool_port[2]);
		pl = {8'h80};
		add_datagram(pl, DG_GOOD, pool_ip[2], pool_port[2]);
		pl = {8'h7F};
		add_datagram(pl, DG_UNMARKED, pool_ip[2], pool_port[2]);
		add_ctrl(crclrm_pkg::KIND_LISTEN, '1, '1);
		wait_drained();

		reg_write(REG_SALT, 32'hFFFFFFFF);
		reg_write(REG_TIMEOUT, 32'd1);
		random_traffic(35);
		wait_drained();

		// back-pressure: receiver holds off while the sender streams
		reg_write(REG_SALT, $urandom);
		reg_write(REG_TIMEOUT, 32'd3);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold_cycles = 300;
		random_traffic(20);
		wait_drained();
		random_traffic(20);
		wait_drained();

		reg_write(REG_SALT, $urandom);
		reg_write(REG_TIMEOUT, 32'h00FFFFFF);
		tx_idle = 1'b1;
		random_traffic(20);
		wait_drained();

		reg_write(REG_SALT, '0);
		reg_write(REG_TIMEOUT, $urandom_range(2, 8));
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		random_traffic(25);
		wait_drained();

		// overlong datagram: bytes past the limit are neither hashed nor passed
		reg_write(REG_SALT, $urandom);
		reg_write(REG_TIMEOUT, 32'd1000);
		rx_idle = 1'b0;
		add_ctrl(crclrm_pkg::KIND_LISTEN, '0, '0);
		add_datagram(rand_body(MAX_BYTES - 3), DG_GOOD, pool_ip[3], pool_port[3]);
		add_ctrl(crclrm_pkg::KIND_TICK, '0, '0);
		add_datagram(rand_body(3), DG_GOOD, pool_ip[3], pool_port[3]);
		wait_drained();

		$display("Covered %0d requests and %0d results over six register settings",
			n_reqs, n_results);
		$display("  %0d datagram ends, %0d accepted, %0d connects, %0d drops, %0d mismatches",
			n_ends, n_ok, n_conn, n_drop, err_count);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
sv/crclrm_pkg.sv
sv/crc32_link_receive_monitor.sv
tb/testbench.sv
